>>> sv/arp_pkg.sv
`default_nettype none
package arp_pkg;

  localparam int unsigned RingDepthDef = 16384;
  localparam int unsigned QueueDepth   = 4;
  localparam int unsigned QueueCntW    = $clog2(QueueDepth + 1);
  localparam int unsigned QueuePtrW    = $clog2(QueueDepth);

  localparam logic [10:0] PktSamplesRst = 11'd480;
  localparam logic [10:0] PktSamplesMax = 11'd1024;
  localparam logic [11:0] HdrLen        = 12'd8;

  localparam logic [7:0] Sync0Byte = 8'hAA;
  localparam logic [7:0] Sync1Byte = 8'h55;
  localparam logic [7:0] FlagsByte = 8'h00;

  localparam logic OpPush = 1'b0;
  localparam logic OpPull = 1'b1;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_HDR,
    KIND_LOAD,
    KIND_MID,
    KIND_HIGH
  } arp_kind_e;

  typedef struct packed {
    arp_kind_e   kind;
    logic [7:0]  hdr_byte;
    logic [23:0] sample;
    logic        first;
    logic        last;
    logic        dropped;
    logic [14:0] fill;
  } arp_entry_t;

  typedef struct packed {
    logic [QueueCntW-1:0] count;
    logic                 not_empty;
  } arp_qstat_t;

endpackage
`default_nettype wire

>>> sv/arp_front.sv
`default_nettype none
module arp_front #(
  parameter int unsigned RING_DEPTH = arp_pkg::RingDepthDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [10:0]        packet_samples_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               opcode_i,
  input  wire logic [31:0]        sample_word_i,
  input  wire arp_pkg::arp_qstat_t qstat_i,
  output logic                    push_o,
  output arp_pkg::arp_entry_t     entry_o
);
  import arp_pkg::*;

  localparam int unsigned IW = $clog2(RING_DEPTH);
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);

  logic [23:0] mem_q [RING_DEPTH];
  logic [23:0] rdata_q;

  logic [IW-1:0] wr_idx_q, wr_idx_d, rd_idx_q, rd_idx_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [7:0]    seq_q, seq_d;
  logic [31:0]   ts_q, ts_d;
  logic [11:0]   pos_q, pos_d;
  logic [1:0]    ph_q, ph_d;
  logic          active_q, active_d;

  logic       s2_valid_q;
  arp_entry_t s2_q, s2_d;
  logic       s2_underrun_q, underrun;

  logic        accept, mem_we, mem_re;
  logic [10:0] ps;
  logic [11:0] plen, pos;
  logic [1:0]  ph;
  logic        act;
  logic [QueueCntW:0] occupancy;

  function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] idx);
    return (idx == IW'(RING_DEPTH - 1)) ? '0 : IW'(idx + IW'(1));
  endfunction

  assign occupancy  = {1'b0, qstat_i.count} + {{QueueCntW{1'b0}}, s2_valid_q};
  assign in_stall_o = (occupancy >= (QueueCntW + 1)'(QueueDepth));
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    if (packet_samples_i == 11'd0) begin
      ps = 11'd1;
    end else if (packet_samples_i > PktSamplesMax) begin
      ps = PktSamplesMax;
    end else begin
      ps = packet_samples_i;
    end
  end

  assign plen = HdrLen + {1'b0, ps} + {ps, 1'b0};

  always_comb begin
    wr_idx_d = wr_idx_q;
    rd_idx_d = rd_idx_q;
    cnt_d    = cnt_q;
    seq_d    = seq_q;
    ts_d     = ts_q;
    pos_d    = pos_q;
    ph_d     = ph_q;
    active_d = active_q;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    underrun = 1'b0;
    act      = 1'b0;
    pos      = pos_q;
    ph       = ph_q;
    s2_d          = '0;
    s2_d.kind     = KIND_NONE;
    s2_d.hdr_byte = FlagsByte;
    if (accept) begin
      if (opcode_i == OpPush) begin
        mem_we   = 1'b1;
        wr_idx_d = next_idx(wr_idx_q);
        if (cnt_q == CW'(RING_DEPTH)) begin
          rd_idx_d     = next_idx(rd_idx_q);
          s2_d.dropped = 1'b1;
        end else begin
          cnt_d = CW'(cnt_q + CW'(1));
        end
      end else begin
        if (!active_q && (cnt_q >= CW'(ps))) begin
          act = 1'b1;
          pos = '0;
          ph  = '0;
        end else begin
          act = active_q;
        end
        if (act) begin
          s2_d.first = (pos == 12'd0);
          if (pos < HdrLen) begin
            s2_d.kind = KIND_HDR;
            case (pos[2:0])
              3'd0:    s2_d.hdr_byte = Sync0Byte;
              3'd1:    s2_d.hdr_byte = Sync1Byte;
              3'd2:    s2_d.hdr_byte = seq_q;
              3'd3:    s2_d.hdr_byte = FlagsByte;
              3'd4:    s2_d.hdr_byte = ts_q[7:0];
              3'd5:    s2_d.hdr_byte = ts_q[15:8];
              3'd6:    s2_d.hdr_byte = ts_q[23:16];
              default: s2_d.hdr_byte = ts_q[31:24];
            endcase
            ph_d = ph;
          end else begin
            case (ph)
              2'd0: begin
                s2_d.kind = KIND_LOAD;
                if (cnt_q != '0) begin
                  mem_re   = 1'b1;
                  rd_idx_d = next_idx(rd_idx_q);
                  cnt_d    = CW'(cnt_q - CW'(1));
                end else begin
                  underrun = 1'b1;
                end
                ph_d = 2'd1;
              end
              2'd1: begin
                s2_d.kind = KIND_MID;
                ph_d      = 2'd2;
              end
              default: begin
                s2_d.kind = KIND_HIGH;
                ph_d      = 2'd0;
              end
            endcase
          end
          if (({1'b0, pos} + 13'd1) >= {1'b0, plen}) begin
            s2_d.last = 1'b1;
            active_d  = 1'b0;
            pos_d     = '0;
            ph_d      = '0;
            seq_d     = 8'(seq_q + 8'd1);
            ts_d      = ts_q + 32'(ps);
          end else begin
            active_d = 1'b1;
            pos_d    = 12'(pos + 12'd1);
          end
        end
      end
      s2_d.fill = 15'(cnt_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_idx_q] <= sample_word_i[31:8];
    end
    if (mem_re) begin
      rdata_q <= mem_q[rd_idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s2_q          <= s2_d;
      s2_underrun_q <= underrun;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q   <= '0;
      rd_idx_q   <= '0;
      cnt_q      <= '0;
      seq_q      <= '0;
      ts_q       <= '0;
      pos_q      <= '0;
      ph_q       <= '0;
      active_q   <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      wr_idx_q   <= wr_idx_d;
      rd_idx_q   <= rd_idx_d;
      cnt_q      <= cnt_d;
      seq_q      <= seq_d;
      ts_q       <= ts_d;
      pos_q      <= pos_d;
      ph_q       <= ph_d;
      active_q   <= active_d;
      s2_valid_q <= accept;
    end
  end

  always_comb begin
    entry_o = s2_q;
    if (s2_q.kind == KIND_LOAD) begin
      entry_o.sample = s2_underrun_q ? 24'd0 : rdata_q;
    end
  end

  assign push_o = s2_valid_q;

endmodule
`default_nettype wire

>>> sv/arp_queue.sv
`default_nettype none
module arp_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire arp_pkg::arp_entry_t entry_i,
  input  wire logic                pop_i,
  output arp_pkg::arp_entry_t      entry_o,
  output arp_pkg::arp_qstat_t      qstat_o
);
  import arp_pkg::*;

  arp_entry_t           slot_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] cnt_q, cnt_d;
  logic                 do_pop;

  assign do_pop = pop_i & (cnt_q != '0);

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = QueueCntW'(cnt_q + QueueCntW'(1));
    end else if (!push_i && do_pop) begin
      cnt_d = QueueCntW'(cnt_q - QueueCntW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= QueuePtrW'(wr_ptr_q + QueuePtrW'(1));
      end
      if (do_pop) begin
        rd_ptr_q <= QueuePtrW'(rd_ptr_q + QueuePtrW'(1));
      end
      cnt_q <= cnt_d;
    end
  end

  assign entry_o           = slot_q[rd_ptr_q];
  assign qstat_o.count     = cnt_q;
  assign qstat_o.not_empty = (cnt_q != '0);

endmodule
`default_nettype wire

>>> sv/arp_back.sv
`default_nettype none
module arp_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                avail_i,
  input  wire arp_pkg::arp_entry_t entry_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic                     byte_valid_o,
  output logic [7:0]               data_byte_o,
  output logic                     packet_first_o,
  output logic                     packet_last_o,
  output logic                     sample_dropped_o,
  output logic [14:0]              fill_level_o
);
  import arp_pkg::*;

  logic        ovalid_q;
  logic [23:0] cur_q, cur_d;
  logic        bvalid_q, bvalid_d;
  logic [7:0]  byte_q, byte_d;
  logic        first_q, last_q, drop_q;
  logic [14:0] fill_q;

  assign pop_o = avail_i & (~ovalid_q | ~out_stall_i);

  always_comb begin
    cur_d    = cur_q;
    bvalid_d = 1'b1;
    byte_d   = 8'd0;
    case (entry_i.kind)
      KIND_HDR:  byte_d = entry_i.hdr_byte;
      KIND_LOAD: begin
        cur_d  = entry_i.sample;
        byte_d = entry_i.sample[7:0];
      end
      KIND_MID:  byte_d = cur_q[15:8];
      KIND_HIGH: byte_d = cur_q[23:16];
      default:   bvalid_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      bvalid_q <= bvalid_d;
      byte_q   <= byte_d;
      first_q  <= entry_i.first;
      last_q   <= entry_i.last;
      drop_q   <= entry_i.dropped;
      fill_q   <= entry_i.fill;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      cur_q    <= '0;
    end else begin
      if (pop_o) begin
        ovalid_q <= 1'b1;
        cur_q    <= cur_d;
      end else if (!out_stall_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = ovalid_q;
  assign byte_valid_o     = bvalid_q;
  assign data_byte_o      = byte_q;
  assign packet_first_o   = first_q;
  assign packet_last_o    = last_q;
  assign sample_dropped_o = drop_q;
  assign fill_level_o     = fill_q;

endmodule
`default_nettype wire

>>> sv/audio_ring_packetizer.sv
// path from request accept to out_valid_o: ring read, queue, output register
// throughput: one request per cycle while in_stall_o is low, set by the single ring write/read port and 4-entry queue
// input stalls only when queue plus the request in flight would exceed 4 entries
// reset: indices, fill count, sequence, sample counter and packet state clear at once
// reset: packet_samples returns to 480; ring contents are undefined until written
`default_nettype none
module audio_ring_packetizer #(
  parameter int unsigned RING_DEPTH = arp_pkg::RingDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [10:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        opcode_i,
  input  wire logic [31:0] sample_word_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             byte_valid_o,
  output logic [7:0]       data_byte_o,
  output logic             packet_first_o,
  output logic             packet_last_o,
  output logic             sample_dropped_o,
  output logic [14:0]      fill_level_o
);
  import arp_pkg::*;

  logic [10:0] pkt_samples_q;
  logic        push, pop;
  arp_entry_t  front_entry, queue_entry;
  arp_qstat_t  qstat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_samples_q <= PktSamplesRst;
    end else if (cfg_we_i) begin
      pkt_samples_q <= cfg_wdata_i;
    end
  end

  arp_front #(
    .RING_DEPTH (RING_DEPTH)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .packet_samples_i (pkt_samples_q),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode_i),
    .sample_word_i    (sample_word_i),
    .qstat_i          (qstat),
    .push_o           (push),
    .entry_o          (front_entry)
  );

  arp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .pop_i   (pop),
    .entry_o (queue_entry),
    .qstat_o (qstat)
  );

  arp_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .avail_i          (qstat.not_empty),
    .entry_i          (queue_entry),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .byte_valid_o     (byte_valid_o),
    .data_byte_o      (data_byte_o),
    .packet_first_o   (packet_first_o),
    .packet_last_o    (packet_last_o),
    .sample_dropped_o (sample_dropped_o),
    .fill_level_o     (fill_level_o)
  );

endmodule
`default_nettype wire

>>> tb/sv/audio_ring_packetizer_test.sv
`timescale 1ns / 1ps
module audio_ring_packetizer_test;
  import arp_pkg::*;

  // smallest ring that holds a packet of the largest size
  localparam int unsigned RingDepth  = 1024;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 80;
  localparam int          DirRows    = 23;
  localparam int          NumPhases  = 8;
  localparam int          MaxReports = 10;

  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  data_byte;
    logic        first;
    logic        last;
    logic        dropped;
    logic [14:0] fill;
  } ring_result_t;

  typedef enum logic [1:0] {ROW_PUSH, ROW_PULL, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e    kind;
    logic [31:0]  value;
    bit           typed;
    ring_result_t res;
  } dir_row_t;

  typedef struct {
    logic [10:0] samples;
    int          src_idle_pct;
    int          sink_stall_pct;
    int          requests;
    int          push_pct;
    bit          pressure;
  } phase_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [10:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        opcode = OpPush;
  logic [31:0] sample_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        byte_valid;
  logic [7:0]  data_byte;
  logic        packet_first;
  logic        packet_last;
  logic        sample_dropped;
  logic [14:0] fill_level;

  // packetizer state as the block should hold it
  logic [23:0] sample_ring [RingDepth];
  int unsigned wr_idx = 0;
  int unsigned rd_idx = 0;
  int unsigned unread = 0;
  logic [7:0]  seq_num = '0;
  logic [31:0] stamp = '0;
  int unsigned byte_pos = 0;
  bit          in_packet = 1'b0;
  logic [23:0] cur_sample = '0;
  logic [10:0] pkt_samples = PktSamplesRst;

  ring_result_t pending_results[$];
  dir_row_t     directed_rows [DirRows];
  phase_t       phases [NumPhases];

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  bit hold_req = 1'b0;
  int unsigned cycle_cnt = 0;
  int fail_count = 0;
  int results_checked = 0;
  int push_count = 0;
  int pull_count = 0;
  int packet_count = 0;
  int drop_count = 0;
  int underrun_count = 0;
  int cfg_count = 0;

  audio_ring_packetizer #(
    .RING_DEPTH(RingDepth)
  ) i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .opcode_i        (opcode),
    .sample_word_i   (sample_word),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .byte_valid_o    (byte_valid),
    .data_byte_o     (data_byte),
    .packet_first_o  (packet_first),
    .packet_last_o   (packet_last),
    .sample_dropped_o(sample_dropped),
    .fill_level_o    (fill_level)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic ring_result_t packetize(input logic op, input logic [31:0] word);
    ring_result_t r;
    int unsigned  eff;
    int unsigned  plen;
    int unsigned  k;
    r = '0;
    if (op == OpPush) begin
      sample_ring[wr_idx] = word[31:8];
      wr_idx = (wr_idx + 1) % RingDepth;
      if (unread >= RingDepth) begin
        rd_idx = (rd_idx + 1) % RingDepth;
        r.dropped = 1'b1;
        drop_count++;
      end else begin
        unread++;
      end
    end else begin
      if (pkt_samples == 0) eff = 1;
      else if (pkt_samples > PktSamplesMax) eff = PktSamplesMax;
      else eff = pkt_samples;
      if (!in_packet && unread >= eff) begin
        in_packet = 1'b1;
        byte_pos = 0;
      end
      if (in_packet) begin
        plen = HdrLen + 3 * eff;
        r.byte_valid = 1'b1;
        r.first = (byte_pos == 0);
        if (byte_pos == 0) r.data_byte = Sync0Byte;
        else if (byte_pos == 1) r.data_byte = Sync1Byte;
        else if (byte_pos == 2) r.data_byte = seq_num;
        else if (byte_pos == 3) r.data_byte = FlagsByte;
        else if (byte_pos < HdrLen) r.data_byte = stamp[8 * (byte_pos - 4) +: 8];
        else begin
          k = (byte_pos - HdrLen) % 3;
          if (k == 0) begin
            if (unread != 0) begin
              cur_sample = sample_ring[rd_idx];
              rd_idx = (rd_idx + 1) % RingDepth;
              unread--;
            end else begin
              // ring ran dry after the packet grew
              cur_sample = '0;
              underrun_count++;
            end
          end
          r.data_byte = cur_sample[8 * k +: 8];
        end
        if (byte_pos + 1 >= plen) begin
          r.last = 1'b1;
          in_packet = 1'b0;
          byte_pos = 0;
          seq_num = seq_num + 8'd1;
          stamp = stamp + eff;
          packet_count++;
        end else begin
          byte_pos = byte_pos + 1;
        end
      end
    end
    r.fill = 15'(unread);
    return r;
  endfunction

  function automatic dir_row_t mk(input row_kind_e kind, input logic [31:0] value,
                                  input bit typed, input logic bv, input logic [7:0] db,
                                  input logic first, input logic last, input int fill);
    dir_row_t row;
    row.kind  = kind;
    row.value = value;
    row.typed = typed;
    row.res   = {bv, db, first, last, 1'b0, 15'(fill)};
    return row;
  endfunction

  task automatic send_request(input logic op, input logic [31:0] word, input bit typed,
                              input ring_result_t typed_res);
    ring_result_t predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    sample_word <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = packetize(op, word);
    pending_results.push_back(typed ? typed_res : predicted);
    if (op == OpPush) push_count++;
    else pull_count++;
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_packet_samples(input logic [10:0] value);
    wait_all_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    pkt_samples = value;
    cfg_count++;
  endtask

  // receiver side: random stalls plus one long hold on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < sink_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    ring_result_t got;
    ring_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {byte_valid, data_byte, packet_first, packet_last, sample_dropped, fill_level};
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports)
          $display("unexpected result: valid=%0b byte=%02h fill=%0d",
                   got.byte_valid, got.data_byte, got.fill);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got !== want) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $display("result %0d: exp v=%0b b=%02h f=%0b l=%0b d=%0b n=%0d, %s%0b b=%02h f=%0b l=%0b d=%0b n=%0d",
                     results_checked, want.byte_valid, want.data_byte, want.first,
                     want.last, want.dropped, want.fill, "got v=",
                     got.byte_valid, got.data_byte, got.first, got.last,
                     got.dropped, got.fill);
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("audio_ring_packetizer_test NOT OK");
    $finish;
  end

  initial begin
    directed_rows = '{
      mk(ROW_PULL, 32'h0,        1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 0),
      mk(ROW_PUSH, 32'hFFFFFFFF, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1),
      mk(ROW_CFG,  32'd0,        1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 0),
      mk(ROW_PULL, 32'h0,        1'b1, 1'b1, 8'hAA, 1'b1, 1'b0, 1),
      mk(ROW_PULL, 32'h0,        1'b1, 1'b1, 8'h55, 1'b0, 1'b0, 1),
      mk(ROW_PULL, 32'h0,        1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 0),
      mk(ROW_PULL, 32'h0,        1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 1),
      mk(ROW_PULL, 32'h0,        1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 0),
      mk(ROW_PULL, 32'h0,        1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 0),
      mk(ROW_PULL, 32'h0,        1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 0),
      mk(ROW_PULL, 32'h0,        1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 0),
      mk(ROW_PULL, 32'h0,        1'b1, 1'b1, 8'hFF, 1'b0, 1'b0, 0),
      // packet grows mid-flight, then the ring runs dry
      mk(ROW_CFG,  32'd2,        1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 0),
      mk(ROW_PULL, 32'h0,        1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 0),
      mk(ROW_PULL, 32'h0,        1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 0),
      mk(ROW_PULL, 32'h0,        1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 0),
      mk(ROW_PULL, 32'h0,        1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 0),
      mk(ROW_PULL, 32'h0,        1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 0),
      mk(ROW_PULL, 32'h0,        1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 0),
      mk(ROW_PUSH, 32'h00000000, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1),
      mk(ROW_PUSH, 32'h800000FF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 0),
      mk(ROW_CFG,  32'd2047,     1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 0),
      mk(ROW_PULL, 32'h0,        1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 2)
    };
    phases = '{
      '{11'd1,    0,  0,   60, 40, 1'b0},
      '{11'd3,    62, 0,   60, 45, 1'b0},
      '{11'd2,    0,  62,  60, 40, 1'b0},
      '{11'd0,    20, 20,  60, 25, 1'b0},
      '{11'd1024, 0,  0,  400, 98, 1'b0},
      '{11'd4,    0,  0,  150, 30, 1'b1},
      '{11'd2047, 20, 20,  60, 50, 1'b0},
      '{11'd5,    0,  62,  80, 35, 1'b0}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG)
        write_packet_samples(directed_rows[i].value[10:0]);
      else
        send_request(directed_rows[i].kind == ROW_PULL ? OpPull : OpPush,
                     directed_rows[i].value, directed_rows[i].typed, directed_rows[i].res);
    end

    for (int p = 0; p < NumPhases; p++) begin
      write_packet_samples(phases[p].samples);
      src_idle_pct   = phases[p].src_idle_pct;
      sink_stall_pct = phases[p].sink_stall_pct;
      for (int n = 0; n < phases[p].requests; n++) begin
        // long receiver hold to back up the queue, later a full drain
        if (phases[p].pressure && n == 20) hold_req = 1'b1;
        if (phases[p].pressure && n == 100) wait_all_results();
        send_request(($urandom_range(99) < phases[p].push_pct) ? OpPush : OpPull,
                     $urandom(), 1'b0, '0);
      end
    end

    wait_all_results();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    repeat (10) @(posedge clk);

    $display("%0d pushes and %0d pulls, %0d results checked, %0d packets framed",
             push_count, pull_count, results_checked, packet_count);
    $display("%0d overrun drops, %0d empty-ring sample reads, %0d register writes",
             drop_count, underrun_count, cfg_count);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("audio_ring_packetizer_test OK");
    end else begin
      $display("audio_ring_packetizer_test NOT OK");
    end
    $finish;
  end

endmodule
